// ----- src/sorted_insert_list_queue_defines.svh -----
`ifndef SORTED_INSERT_LIST_QUEUE_DEFINES_SVH
`define SORTED_INSERT_LIST_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SILQ_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication, checked outside reset
`define SILQ_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ----- src/silq_pkg.sv -----
`timescale 1ns / 1ps

package silq_pkg;

    // list size and field widths
    localparam int CAPACITY = 16;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT    = 2'd0,
        OP_INSERT_SORTED = 2'd1,
        OP_POP_FRONT     = 2'd2,
        OP_PEEK_FRONT    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [DATA_W-1:0]   value;
    } cell_ctl_t;

endpackage

// ----- src/silq_cell.sv -----
`timescale 1ns / 1ps

module silq_cell
    import silq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0]  left_data,
    input  logic                      left_valid,
    input  logic signed [DATA_W-1:0]  right_data,
    input  logic                      right_valid,
    input  logic                      keep_in,
    output logic                      keep_out,
    output logic signed [DATA_W-1:0]  data,
    output logic                      valid
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     lt;

    // stored entry is ahead of the new value
    assign lt       = valid_reg && (data_reg < ctl.value);
    assign keep_out = keep_in && lt;

    // hold, open a gap or take the value, or shift toward the front
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctl.op)
            CELL_HOLD:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
            CELL_INSERT:
            begin
                if (keep_in && lt)
                begin
                    data_next  = data_reg;
                    valid_next = valid_reg;
                end
                else if (keep_in)
                begin
                    data_next  = ctl.value;
                    valid_next = 1'b1;
                end
                else
                begin
                    data_next  = left_data;
                    valid_next = left_valid;
                end
            end
            CELL_REMOVE:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // entry occupied flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ----- src/sorted_insert_list_queue.sv -----
`timescale 1ns / 1ps

// Bounded list of CAPACITY signed 32-bit values, held front to back in a row
// of cells. Every request (push front, sorted insert, pop front, peek front)
// finishes in the cycle it is taken: all cells compare against the new value at
// once and a single prefix chain through the row marks the insertion point,
// so a new request is taken every cycle while the result register can be
// emptied. Each request gives one result with the front value (pop and peek),
// a status (ok, empty, full) and the element count after the request.
// A sorted insert goes ahead of the first entry that is not less than the
// value; push front ignores the order. No clearing pass follows reset.
module sorted_insert_list_queue
    import silq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OP_W-1:0]            opcode,
    input  logic signed [DATA_W-1:0]   value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DATA_W-1:0]   result_value,
    output logic [STATUS_W-1:0]        status,
    output logic [COUNT_W-1:0]         count
);

    logic                       accept;
    logic                       is_add;
    logic                       is_read;
    logic                       list_full;
    logic                       list_empty;
    cell_ctl_t                  ctl;

    logic signed [DATA_W-1:0]   cell_data [CAPACITY];
    logic                       cell_valid [CAPACITY];
    logic                       keep [CAPACITY+1];

    logic [OCC_W-1:0]           occ_reg;
    logic [OCC_W-1:0]           occ_next;
    logic                       out_valid_reg;
    logic signed [DATA_W-1:0]   result_reg;
    logic signed [DATA_W-1:0]   result_next;
    logic [STATUS_W-1:0]        status_reg;
    logic [STATUS_W-1:0]        status_next;
    logic [COUNT_W-1:0]         count_reg;

    // handshake: result register frees up when taken
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_add     = (opcode == OP_PUSH_FRONT) || (opcode == OP_INSERT_SORTED);
    assign is_read    = (opcode == OP_POP_FRONT) || (opcode == OP_PEEK_FRONT);
    assign list_full  = (occ_reg == OCC_W'(CAPACITY));
    assign list_empty = (occ_reg == '0);

    // command to the row of cells
    always_comb
    begin
        ctl.value = value;
        ctl.op    = CELL_HOLD;
        if (accept && is_add && !list_full)
            ctl.op = CELL_INSERT;
        else if (accept && (opcode == OP_POP_FRONT) && !list_empty)
            ctl.op = CELL_REMOVE;
    end

    // push front forces the insertion point to the head
    assign keep[0] = (opcode == OP_INSERT_SORTED);

    // the cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] ld;
        logic                     lv;
        logic signed [DATA_W-1:0] rd;
        logic                     rv;

        if (i == 0)
        begin : g_head
            assign ld = value;
            assign lv = 1'b1;
        end
        else
        begin : g_body
            assign ld = cell_data[i-1];
            assign lv = cell_valid[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign rd = '0;
            assign rv = 1'b0;
        end
        else
        begin : g_inner
            assign rd = cell_data[i+1];
            assign rv = cell_valid[i+1];
        end

        silq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_data   (ld),
            .left_valid  (lv),
            .right_data  (rd),
            .right_valid (rv),
            .keep_in     (keep[i]),
            .keep_out    (keep[i+1]),
            .data        (cell_data[i]),
            .valid       (cell_valid[i])
        );
    end

    // result and new occupancy
    always_comb
    begin
        result_next = '0;
        status_next = ST_OK;
        occ_next    = occ_reg;
        case (ctl.op)
            CELL_INSERT: occ_next = occ_reg + OCC_W'(1);
            CELL_REMOVE: occ_next = occ_reg - OCC_W'(1);
            default:     occ_next = occ_reg;
        endcase
        if (is_add && list_full)
            status_next = ST_FULL;
        else if (is_read && list_empty)
            status_next = ST_EMPTY;
        else if (is_read)
            result_next = cell_data[0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
            count_reg  <= COUNT_W'(occ_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign status       = status_reg;
    assign count        = count_reg;

endmodule

// ----- src/silq_checker.sv -----
`timescale 1ns / 1ps
`include "sorted_insert_list_queue_defines.svh"

module silq_checker
    import silq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [DATA_W-1:0]   result_value,
    input  logic [STATUS_W-1:0]        status,
    input  logic [COUNT_W-1:0]         count
);

    // a stalled result holds
    `SILQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(status) && $stable(count), "stalled result changed")

    // empty error reports zero value and zero count
    `SILQ_ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && (status == ST_EMPTY), (result_value == '0) && (count == '0), "empty result not zero")

    // full error only at capacity
    `SILQ_ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid && (status == ST_FULL), count == COUNT_W'(CAPACITY), "full reported below capacity")

    // a waiting result blocks the input side
    `SILQ_ASSERT_IMPLY(a_ready_blocked, clk, rst_n, out_valid && !out_ready, !in_ready, "request taken over a waiting result")

    // every accepted request shows a result on the next cycle
    `SILQ_ASSERT_NEXT(a_req_result, clk, rst_n, in_valid && in_ready, out_valid, "accepted request gave no result")

endmodule

bind sorted_insert_list_queue silq_checker u_silq_checker (.*);
